[rtl/jets_pkg.sv]
// jets_pkg: shared types and fixed constants of the Julia escape-time block.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps
`default_nettype none

package jets_pkg;

   // Input and Julia constant format: signed Q4.28
   localparam int IN_FRAC = 28;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_C_REAL     = 2'd0;
   localparam logic [1:0] REG_C_IMAG     = 2'd1;
   localparam logic [1:0] REG_EXPONENT   = 2'd2;
   localparam logic [1:0] REG_ITER_LIMIT = 2'd3;

   localparam logic [3:0]  EXPONENT_RESET   = 4'd2;
   localparam logic [10:0] ITER_LIMIT_RESET = 11'd256;

   // Configuration as seen by the compute core
   typedef struct packed {
      logic signed [31:0] c_real;
      logic signed [31:0] c_imag;
      logic [3:0]         exponent;
      logic [10:0]        iteration_limit;
   } cfg_type;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic       clear;   // zero the accumulator
      logic       issue;   // start one partial product
      logic       sub;     // subtract this partial
      logic [1:0] part;    // {a half, b half}: 1 = high half
   } mac_ctl_type;

endpackage

`default_nettype wire

[rtl/jets_csr.sv]
// jets_csr: APB-style register file for c, exponent and iteration limit.
// Depends on jets_pkg (register indexes, cfg_type).
`timescale 1ns / 1ps
`default_nettype none

module jets_csr
   import jets_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real          <= '0;
         cfg_ff.c_imag          <= '0;
         cfg_ff.exponent        <= EXPONENT_RESET;
         cfg_ff.iteration_limit <= ITER_LIMIT_RESET;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_C_REAL:     cfg_ff.c_real          <= pwdata;
            REG_C_IMAG:     cfg_ff.c_imag          <= pwdata;
            REG_EXPONENT:   cfg_ff.exponent        <= pwdata[3:0];
            REG_ITER_LIMIT: cfg_ff.iteration_limit <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_C_REAL:     prdata = cfg_ff.c_real;
         REG_C_IMAG:     prdata = cfg_ff.c_imag;
         REG_EXPONENT:   prdata = {28'd0, cfg_ff.exponent};
         REG_ITER_LIMIT: prdata = {21'd0, cfg_ff.iteration_limit};
         default:        prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/jets_mac.sv]
// jets_mac: shared signed multiply-accumulate; a WIDTH x WIDTH product is
// built from four half-width partials, one per cycle. Depends on jets_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jets_mac
   import jets_pkg::*;
#(
   parameter int WIDTH = 40
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mac_ctl_type               ctl,
   input  wire logic signed [WIDTH-1:0]   op_a,
   input  wire logic signed [WIDTH-1:0]   op_b,
   output logic signed [2*WIDTH:0]        acc
);

   localparam int LO    = (WIDTH + 1) / 2;
   localparam int HI    = WIDTH - LO;
   localparam int OPW   = LO + 1;
   localparam int PW    = 2 * OPW;
   localparam int ACC_W = 2 * WIDTH + 1;

   logic signed [OPW-1:0]   a_lo, a_hi, b_lo, b_hi, mul_a, mul_b;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic                    vld_ff, sub_ff;
   logic [1:0]              part_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, ext, term;

   // low halves unsigned, high halves signed
   assign a_lo  = {1'b0, op_a[LO-1:0]};
   assign b_lo  = {1'b0, op_b[LO-1:0]};
   assign a_hi  = {{(OPW-HI){op_a[WIDTH-1]}}, op_a[WIDTH-1:LO]};
   assign b_hi  = {{(OPW-HI){op_b[WIDTH-1]}}, op_b[WIDTH-1:LO]};
   assign mul_a = ctl.part[1] ? a_hi : a_lo;
   assign mul_b = ctl.part[0] ? b_hi : b_lo;
   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      part_ff <= ctl.part;
      sub_ff  <= ctl.sub;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl.issue;
      end
   end

   assign ext = ACC_W'(prod_ff);

   always_comb begin
      case (part_ff)
         2'd0:    term = ext;
         2'd3:    term = ext <<< (2 * LO);
         default: term = ext <<< LO;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (vld_ff) begin
         acc_in = sub_ff ? acc_ff - term : acc_ff + term;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

[rtl/jets_core.sv]
// jets_core: escape-time sequencer driving the shared multiply-accumulate.
// Depends on jets_pkg and jets_mac.
`timescale 1ns / 1ps
`default_nettype none

module jets_core
   import jets_pkg::*;
#(
   parameter int FRACTION_BITS = 28,
   parameter int MAX_EXPONENT  = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                start,
   input  wire logic signed [31:0]  req_start_real,
   input  wire logic signed [31:0]  req_start_imag,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic [10:0]              rsp_step_count,
   output logic                     rsp_inside_set
);

   localparam int W     = FRACTION_BITS + 12;
   localparam int ACC_W = 2 * W + 1;
   localparam int SHL   = (FRACTION_BITS >= IN_FRAC) ? FRACTION_BITS - IN_FRAC : 0;
   localparam int SHR   = (FRACTION_BITS < IN_FRAC) ? IN_FRAC - FRACTION_BITS : 0;
   localparam logic signed [ACC_W-1:0] ESC_LIMIT = ACC_W'(1) << (2 * FRACTION_BITS + 2);
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [3:0] LAST_CNT = 4'd8;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SQR   = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_CRE   = 3'd3;
   localparam logic [2:0] S_CIM   = 3'd4;
   localparam logic [2:0] S_NEXT  = 3'd5;
   localparam logic [2:0] S_ADDC  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [10:0]         k_ff, k_in;
   logic [3:0]          n_ff, n_in, m_ff, m_in;
   logic signed [W-1:0] zr_ff, zr_in, zi_ff, zi_in, tr_ff, tr_in, ti_ff, ti_in;
   logic signed [W-1:0] nr_ff, nr_in, mac_a, mac_b, acc_narrow;
   logic                rsp_valid_ff, rsp_valid_in, inside_ff, inside_in;
   logic [10:0]         count_ff, count_in;
   logic signed [ACC_W-1:0] acc;
   mac_ctl_type         mac_ctl;
   logic                in_phase;

   function automatic logic signed [W-1:0] to_internal(input logic signed [31:0] x);
      logic signed [W+31:0] wide;
      wide = {{W{x[31]}}, x};
      wide = (wide <<< SHL) >>> SHR;
      return wide[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? VMIN : VMAX;
      end
      return s[W-1:0];
   endfunction

   function automatic logic [3:0] clamp_exp(input logic [3:0] e);
      if ({1'b0, e} > 5'(MAX_EXPONENT)) begin
         return 4'(MAX_EXPONENT);
      end
      return e;
   endfunction

   // floor shift by F, then saturate to W bits
   always_comb begin
      logic signed [ACC_W-1:0] sh;
      sh = acc >>> FRACTION_BITS;
      if (sh[ACC_W-1:W-1] == '0 || sh[ACC_W-1:W-1] == '1) begin
         acc_narrow = sh[W-1:0];
      end else begin
         acc_narrow = sh[ACC_W-1] ? VMIN : VMAX;
      end
   end

   assign in_phase     = (state_ff == S_SQR) || (state_ff == S_CRE) || (state_ff == S_CIM);
   assign mac_ctl.clear = in_phase && (cnt_ff == 4'd0);
   assign mac_ctl.issue = in_phase && !cnt_ff[3];
   assign mac_ctl.sub   = (state_ff == S_CRE) && cnt_ff[2];
   assign mac_ctl.part  = cnt_ff[1:0];

   // operand pairs: cnt[2] picks the second term of the sum
   always_comb begin
      unique case (state_ff)
         S_SQR: begin
            mac_a = cnt_ff[2] ? zi_ff : zr_ff;
            mac_b = cnt_ff[2] ? zi_ff : zr_ff;
         end
         S_CRE: begin
            mac_a = cnt_ff[2] ? ti_ff : tr_ff;
            mac_b = cnt_ff[2] ? zi_ff : zr_ff;
         end
         S_CIM: begin
            mac_a = cnt_ff[2] ? ti_ff : tr_ff;
            mac_b = cnt_ff[2] ? zr_ff : zi_ff;
         end
         default: begin
            mac_a = zr_ff;
            mac_b = zr_ff;
         end
      endcase
   end

   jets_mac #(
      .WIDTH (W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      tr_in        = tr_ff;
      ti_in        = ti_ff;
      nr_in        = nr_ff;
      rsp_valid_in = 1'b0;
      inside_in    = inside_ff;
      count_in     = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               zr_in    = to_internal(req_start_real);
               zi_in    = to_internal(req_start_imag);
               k_in     = '0;
               n_in     = clamp_exp(cfg.exponent);
               cnt_in   = '0;
               state_in = S_SQR;
            end
         end
         S_SQR, S_CRE, S_CIM: begin
            if (state_ff == S_CIM && cnt_ff == 4'd0) begin
               nr_in = acc_narrow;
            end
            if (cnt_ff == LAST_CNT) begin
               cnt_in = '0;
               unique case (state_ff)
                  S_SQR:   state_in = S_CHECK;
                  S_CRE:   state_in = S_CIM;
                  default: state_in = S_NEXT;
               endcase
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_CHECK: begin
            tr_in = zr_ff;
            ti_in = zi_ff;
            m_in  = 4'd1;
            if (k_ff >= cfg.iteration_limit) begin
               rsp_valid_in = 1'b1;
               count_in     = k_ff;
               inside_in    = 1'b1;
               state_in     = S_IDLE;
            end else if (acc > ESC_LIMIT) begin
               rsp_valid_in = 1'b1;
               count_in     = k_ff;
               inside_in    = 1'b0;
               state_in     = S_IDLE;
            end else if (n_ff <= 4'd1) begin
               state_in = S_ADDC;
            end else begin
               state_in = S_CRE;
            end
         end
         S_NEXT: begin
            tr_in = nr_ff;
            ti_in = acc_narrow;
            m_in  = m_ff + 4'd1;
            state_in = ((m_ff + 4'd1) < n_ff) ? S_CRE : S_ADDC;
         end
         S_ADDC: begin
            zr_in    = sat_add(tr_ff, to_internal(cfg.c_real));
            zi_in    = sat_add(ti_ff, to_internal(cfg.c_imag));
            k_in     = k_ff + 11'd1;
            cnt_in   = '0;
            state_in = S_SQR;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      tr_ff     <= tr_in;
      ti_ff     <= ti_in;
      nr_ff     <= nr_in;
      inside_ff <= inside_in;
      count_ff  <= count_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_count = count_ff;
   assign rsp_inside_set = inside_ff;

`ifndef SYNTH
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_escape_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_set) |-> (rsp_step_count < cfg.iteration_limit))
      else $error("escape reported at or past the limit");

   a_check_after_sqr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_SQR))
      else $error("escape check without a fresh |z|^2");
`endif

endmodule

`default_nettype wire

[rtl/julia_escape_time_power_n.sv]
// julia_escape_time_power_n: top level of the Julia escape-time block.
// Depends on jets_pkg, jets_csr, jets_core (which holds jets_mac).
`timescale 1ns / 1ps
`default_nettype none

// Escape-time kernel for z -> z^n + c. A transaction is taken when start is
// high and busy is low; req_start_real/imag give z0 in signed Q4.28. The
// result (rsp_step_count, rsp_inside_set) appears for exactly one cycle with
// rsp_valid; the receiver cannot stall it, so it must capture it then. busy
// falls in that same cycle, so the next transaction may start right away.
// All products go through one shared multiply-accumulate unit that builds a
// (F+12) x (F+12)-bit product from four half-width partials, one per cycle.
// Per transaction, busy stays high for K steps and then a final |z|^2 and
// check, K being the reported step count. Each step is a |z|^2 phase, one
// check state, n - 1 complex products and one add-c state; with n <= 1
// there are no complex products. Arithmetic is Q12.F internally
// (F = FRACTION_BITS), products floor-shifted and saturated. Configuration
// (c_real 0x0, c_imag 0x4, exponent 0x8, iteration_limit 0xC) may only be
// written while busy is low.

module julia_escape_time_power_n
   import jets_pkg::*;
#(
   parameter int FRACTION_BITS = 28,
   parameter int MAX_EXPONENT  = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input transaction
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_start_real,
   input  wire logic signed [31:0] req_start_imag,
   // result transaction
   output logic                    rsp_valid,
   output logic [10:0]             rsp_step_count,
   output logic                    rsp_inside_set,
   // configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   cfg_type cfg;

   jets_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   jets_core #(
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_EXPONENT  (MAX_EXPONENT)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .start          (start),
      .req_start_real (req_start_real),
      .req_start_imag (req_start_imag),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_step_count (rsp_step_count),
      .rsp_inside_set (rsp_inside_set)
   );

endmodule

`default_nettype wire

[bench/julia_escape_time_power_n_tb.sv]
// Self-checking bench for julia_escape_time_power_n: an in-bench escape-time predictor,
// directed corner points, then randomized points over many register settings.
// Depends on jets_pkg and the julia_escape_time_power_n RTL only.
`timescale 1ns / 1ps

module julia_escape_time_power_n_tb;
   import jets_pkg::*;

   // Internal format of the block: Q12.FB in W bits, products 2*W+2 wide
   localparam int FB      = 28;
   localparam int MAX_EXP = 8;
   localparam int W       = FB + 12;

   typedef logic signed [W-1:0]   zval_type;
   typedef logic signed [2*W+1:0] wide_type;

   localparam zval_type ZMAX = {1'b0, {(W-1){1'b1}}};
   localparam zval_type ZMIN = {1'b1, {(W-1){1'b0}}};
   // 4.0 with 2*FB fraction bits, the escape threshold on |z|^2
   localparam wide_type ESCAPE_THRESH = wide_type'(1) <<< (2 * FB + 2);

   // Handy Q4.28 values
   localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] Q_TWO  = 32'sh2000_0000;
   localparam logic signed [31:0] Q_ONE  = 32'sh1000_0000;
   localparam logic signed [31:0] Q_HALF = 32'sh0800_0000;
   localparam int Z_SPAN = 32'h2400_0000;   // 2.25
   localparam int C_SPAN = 32'h1800_0000;   // 1.5
   localparam int S_SPAN = 32'h0800_0000;   // 0.5

   localparam int RANDOM_TOTAL = 900;

   typedef struct packed {
      int unsigned item;
      logic [10:0] steps;
      logic        in_set;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic signed [31:0] req_start_real, req_start_imag;
   logic rsp_valid;
   logic [10:0] rsp_step_count;
   logic rsp_inside_set;
   logic psel, penable, pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   // Bench copy of the register file, updated on each CSR write
   cfg_type active_cfg;
   // Expected results of accepted transactions, oldest first
   pixel_result_type expected_pixels[$];

   int unsigned items_sent;
   int unsigned inside_count;
   int unsigned settings_count;
   int unsigned max_steps_seen;
   int unsigned mismatch_count;
   int unsigned burst_left;
   pixel_result_type want;

   julia_escape_time_power_n #(
      .FRACTION_BITS(FB),
      .MAX_EXPONENT (MAX_EXP)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_start_real(req_start_real),
      .req_start_imag(req_start_imag),
      .rsp_valid     (rsp_valid),
      .rsp_step_count(rsp_step_count),
      .rsp_inside_set(rsp_inside_set),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // 8 ns clock, first rising edge at 4 ns
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Clamp an exact value to the W-bit signed range
   function automatic zval_type saturate_w(input wide_type v);
      if (v > wide_type'(ZMAX)) return ZMAX;
      if (v < wide_type'(ZMIN)) return ZMIN;
      return zval_type'(v);
   endfunction

   // Escape-time count for one start point under the given settings.
   // Each step: test |z|^2 > 4 exactly, else z = z^n + c, where the power is
   // built by n-1 floor-shifted, saturated complex products.
   function automatic pixel_result_type escape_time(input cfg_type cfg,
                                                    input logic signed [31:0] sr,
                                                    input logic signed [31:0] si);
      zval_type zr, zi, tr, ti, cr, ci;
      wide_type mag, re_acc, im_acc;
      int unsigned n, m, k;
      pixel_result_type res;
      // Q4.28 -> Q12.FB; sign extension, no rounding for FB >= 28
      zr = zval_type'(sr) <<< (FB - IN_FRAC);
      zi = zval_type'(si) <<< (FB - IN_FRAC);
      cr = zval_type'(cfg.c_real) <<< (FB - IN_FRAC);
      ci = zval_type'(cfg.c_imag) <<< (FB - IN_FRAC);
      // exponent above the maximum is clamped; zero or one means z + c
      n = (cfg.exponent > MAX_EXP) ? MAX_EXP : cfg.exponent;
      res.item   = 0;
      res.steps  = cfg.iteration_limit;   // limit zero: no test, inside
      res.in_set = 1'b1;
      for (k = 0; k < cfg.iteration_limit; k++) begin
         mag = wide_type'(zr) * wide_type'(zr) + wide_type'(zi) * wide_type'(zi);
         if (mag > ESCAPE_THRESH) begin
            res.steps  = k[10:0];
            res.in_set = 1'b0;
            break;
         end
         tr = zr;
         ti = zi;
         for (m = 1; m < n; m++) begin
            re_acc = wide_type'(tr) * wide_type'(zr) - wide_type'(ti) * wide_type'(zi);
            im_acc = wide_type'(tr) * wide_type'(zi) + wide_type'(ti) * wide_type'(zr);
            tr = saturate_w(re_acc >>> FB);
            ti = saturate_w(im_acc >>> FB);
         end
         zr = saturate_w(wide_type'(tr) + wide_type'(cr));
         zi = saturate_w(wide_type'(ti) + wide_type'(ci));
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Shared plumbing
   // ------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input longint expv, input longint actv);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %s: expected %0d, got %0d", what, expv, actv);
   endtask

   // One APB transfer: setup, access, then an idle state with psel low so that
   // back-to-back transfers never assign psel twice in a time step.
   task automatic csr_cycle(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Read one register back and compare with the bench copy
   task automatic csr_check(input logic [1:0] idx);
      logic [31:0] got, exp_val;
      csr_cycle(1'b0, idx, 32'h0, got);
      case (idx)
         REG_C_REAL:     exp_val = active_cfg.c_real;
         REG_C_IMAG:     exp_val = active_cfg.c_imag;
         REG_EXPONENT:   exp_val = 32'(active_cfg.exponent);
         REG_ITER_LIMIT: exp_val = 32'(active_cfg.iteration_limit);
         default:        exp_val = 32'h0;
      endcase
      if (got !== exp_val)
         flag_mismatch($sformatf("register %0d readback", idx), exp_val, got);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_cycle(1'b1, idx, value, unused);
      case (idx)
         REG_C_REAL:     active_cfg.c_real          = value;
         REG_C_IMAG:     active_cfg.c_imag          = value;
         REG_EXPONENT:   active_cfg.exponent        = value[3:0];
         REG_ITER_LIMIT: active_cfg.iteration_limit = value[10:0];
         default:        ;
      endcase
      csr_check(idx);
   endtask

   // Every transaction yields exactly one result, so an empty queue means
   // the block is idle; spare cycles are added anyway.
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input logic signed [31:0] cr, input logic signed [31:0] ci,
                               input logic [3:0] n, input logic [10:0] lim);
      wait_idle();
      csr_write(REG_C_REAL, cr);
      csr_write(REG_C_IMAG, ci);
      csr_write(REG_EXPONENT, 32'(n));
      csr_write(REG_ITER_LIMIT, 32'(lim));
      settings_count++;
   endtask

   // Send one point. start stays high after acceptance unless a gap starts,
   // so consecutive transactions in a burst never toggle start in one step.
   // busy is read right after the edge, i.e. the value the block saw there.
   task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
      pixel_result_type res;
      int unsigned gap;
      start          <= 1'b1;
      req_start_real <= re;
      req_start_imag <= im;
      do @(posedge clock); while (busy);
      res      = escape_time(active_cfg, re, im);
      res.item = items_sent;
      expected_pixels.push_back(res);
      items_sent++;
      if (res.in_set) inside_count++;
      if (res.steps > max_steps_seen) max_steps_seen = res.steps;
      // burst / gap pattern of the sender; a quarter of bursts run on with no gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: the block cannot be stalled, so every strobe is taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            flag_mismatch("unexpected result, step_count", -1, rsp_step_count);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_step_count !== want.steps)
               flag_mismatch($sformatf("item %0d step_count", want.item),
                             want.steps, rsp_step_count);
            if (rsp_inside_set !== want.in_set)
               flag_mismatch($sformatf("item %0d inside_set", want.item),
                             want.in_set, rsp_inside_set);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values, then corner points under the default c = 0, n = 2, 256 steps
   task automatic test_reset_defaults();
      csr_check(REG_C_REAL);
      csr_check(REG_C_IMAG);
      csr_check(REG_EXPONENT);
      csr_check(REG_ITER_LIMIT);
      send_point(32'sh0, 32'sh0);              // origin: never escapes
      send_point(Q_MAX, Q_MAX);                // field extremes escape at once
      send_point(Q_MIN, Q_MIN);
      send_point(Q_MAX, Q_MIN);
      send_point(Q_TWO, 32'sh0);               // |z|^2 exactly 4: not an escape
      send_point(32'sh0, -Q_TWO);
      send_point(Q_TWO + 32'sh1, 32'sh0);      // one LSB past the circle
      send_point(Q_HALF, Q_HALF);              // shrinks toward 0: inside
   endtask

   // Every exponent class: zero and one (plain z + c), mid, max, above max
   task automatic test_exponent_range();
      logic [3:0] n_list[6];
      n_list = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd9, 4'd15};
      foreach (n_list[i]) begin
         apply_config(32'shF333_3333, 32'sh027E_D917, n_list[i], 11'd16);
         send_point(32'sh04CC_CCCD, -32'sh0666_6666);
      end
   endtask

   // Iteration limit at zero, one, the nominal maximum and the top of the field
   task automatic test_limit_extremes();
      apply_config(32'sh0, 32'sh0, 4'd2, 11'd0);
      send_point(32'sh0, 32'sh0);              // no test made: 0 steps, inside
      send_point(Q_MAX, Q_MAX);
      apply_config(32'sh0, 32'sh0, 4'd2, 11'd1);
      send_point(32'sh0, 32'sh0);
      apply_config(32'sh0, 32'sh0, 4'd1, 11'd1024);
      send_point(32'sh0, 32'sh0);              // inside after all 1024 tests
      // z drifts by 2^-8 per step, escaping late into the 11-bit count
      apply_config(32'sh0010_0000, 32'sh0, 4'd1, 11'd2047);
      send_point(-Q_TWO, 32'sh0);
   endtask

   // Julia constant at the ends of its range
   task automatic test_c_extremes();
      apply_config(Q_MAX, Q_MIN, 4'd2, 11'd8);
      send_point(32'sh0, 32'sh0);
      apply_config(Q_MIN, Q_MAX, 4'd8, 11'd8);
      send_point(Q_ONE, -Q_ONE);
   endtask

   // Random settings in phases. Limits stay short so high powers remain
   // cheap; points mostly lie near the interesting disk around the origin.
   task automatic test_random_points(input int unsigned total);
      int unsigned phase_len, sel, n;
      logic signed [31:0] cr, ci, re, im;
      logic [10:0] lim;
      while (items_sent < total) begin
         cr  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 2 * C_SPAN)) - C_SPAN
                                          : $urandom;
         ci  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 2 * C_SPAN)) - C_SPAN
                                          : $urandom;
         n   = $urandom_range(0, 15);
         lim = (n >= 5) ? 11'($urandom_range(1, 12)) : 11'($urandom_range(1, 32));
         if ($urandom_range(0, 19) == 0) lim = 11'd0;
         apply_config(cr, ci, 4'(n), lim);
         phase_len = $urandom_range(30, 70);
         repeat (phase_len) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
               re = int'($urandom_range(0, 2 * Z_SPAN)) - Z_SPAN;
               im = int'($urandom_range(0, 2 * Z_SPAN)) - Z_SPAN;
            end else if (sel == 6) begin
               re = $urandom;
               im = $urandom;
            end else if (sel < 9) begin
               re = int'($urandom_range(0, 2 * S_SPAN)) - S_SPAN;
               im = int'($urandom_range(0, 2 * S_SPAN)) - S_SPAN;
            end else begin
               // a few LSBs either side of the |z| = 2 circle on an axis
               re = Q_TWO + int'($urandom_range(0, 32)) - 16;
               if ($urandom_range(0, 1)) re = -re;
               im = int'($urandom_range(0, 32)) - 16;
               if ($urandom_range(0, 1)) {re, im} = {im, re};
            end
            send_point(re, im);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_start_real <= '0;
      req_start_imag <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      active_cfg.c_real          = '0;
      active_cfg.c_imag          = '0;
      active_cfg.exponent        = EXPONENT_RESET;
      active_cfg.iteration_limit = ITER_LIMIT_RESET;
      items_sent     = 0;
      inside_count   = 0;
      settings_count = 1;
      max_steps_seen = 0;
      mismatch_count = 0;
      burst_left     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_exponent_range();
      test_limit_extremes();
      test_c_extremes();
      test_random_points(RANDOM_TOTAL);

      // drain, then let the block settle before judging
      wait_idle();
      repeat (50) @(posedge clock);
      mismatch_count += expected_pixels.size();

      $display("Covered %0d points over %0d register settings (%0d inside, longest count %0d).",
               items_sent, settings_count, inside_count, max_steps_seen);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("julia_escape_time_power_n test passed");
      end else begin
         $display("julia_escape_time_power_n test failed");
      end
      $finish;
   end

   // Watchdog. The slowest legal run is the directed points plus up to about 970
   // points in all, the costliest random ones at n = 4 with 32 steps, with
   // sender gaps; that comes to about 19 ms, and 200 ms leaves ample margin.
   initial begin
      #200_000_000;
      $display("Timeout with %0d results outstanding", expected_pixels.size());
      $display("julia_escape_time_power_n test failed");
      $finish;
   end

endmodule
